FILE: rtl/core/oriented_box_overlap_test_top_macros.svh
// assertion macros shared by the oriented box overlap test modules
`ifndef ORIENTED_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OBOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("obot: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define OBOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("obot: next-cycle check failed");

`endif

FILE: rtl/core/obot_pkg.sv
// package: constants, pair tables and helpers for the oriented box overlap test
`timescale 1ns / 1ps

package obot_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// pair kinds
	localparam logic OP_RECT   = 1'b0;
	localparam logic OP_CIRCLE = 1'b1;

	localparam int NUM_EDGES   = 4;
	localparam int NUM_PAIRS   = 10;
	localparam int BACK_STAGES = 6;

	// unique edge pairs of the symmetric dot product matrix
	localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
	localparam int PAIR_B [NUM_PAIRS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

	// pair slot for edge j projected onto axis i
	localparam int PAIR_IDX [NUM_EDGES][NUM_EDGES] = '{
		'{0, 1, 2, 3},
		'{1, 4, 5, 6},
		'{2, 5, 7, 8},
		'{3, 6, 8, 9}
	};

	// queue entry: kind, centre difference, edges, diameter sum
	function automatic int entry_bits(input int coord_bits);
		return 1 + (2 + 2 * NUM_EDGES) * coord_bits + coord_bits + 1;
	endfunction

endpackage

FILE: rtl/core/obot_ifs.sv
// interfaces: request, response and internal stream channels
`timescale 1ns / 1ps

interface obot_req_if #(
	parameter int COORD_BITS = obot_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic signed [COORD_BITS-1:0] center_dx;
	logic signed [COORD_BITS-1:0] center_dy;
	logic signed [COORD_BITS-1:0] left_width_edge_x;
	logic signed [COORD_BITS-1:0] left_width_edge_y;
	logic signed [COORD_BITS-1:0] left_height_edge_x;
	logic signed [COORD_BITS-1:0] left_height_edge_y;
	logic signed [COORD_BITS-1:0] right_width_edge_x;
	logic signed [COORD_BITS-1:0] right_width_edge_y;
	logic signed [COORD_BITS-1:0] right_height_edge_x;
	logic signed [COORD_BITS-1:0] right_height_edge_y;

	modport source (
		output valid, opcode, center_dx, center_dy,
		output left_width_edge_x, left_width_edge_y, left_height_edge_x, left_height_edge_y,
		output right_width_edge_x, right_width_edge_y, right_height_edge_x, right_height_edge_y,
		input  ready
	);
	modport sink (
		input  valid, opcode, center_dx, center_dy,
		input  left_width_edge_x, left_width_edge_y, left_height_edge_x, left_height_edge_y,
		input  right_width_edge_x, right_width_edge_y, right_height_edge_x, right_height_edge_y,
		output ready
	);
endinterface

interface obot_rsp_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

interface obot_stream_if #(
	parameter int WIDTH = 8
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/obot_front.sv
// front end: takes request beats, works out the circle diameter sum, packs queue entries
`timescale 1ns / 1ps

module obot_front #(
	parameter int COORD_BITS = obot_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	obot_req_if.sink             req,
	obot_stream_if.source        wr
);

	localparam int EW = obot_pkg::entry_bits(COORD_BITS);

	logic signed [COORD_BITS:0] dsum;
	logic                       vld_q;
	logic [EW-1:0]              data_q;
	logic                       take;

	// diameter sum only matters for circle pairs
	assign dsum = (req.opcode == obot_pkg::OP_CIRCLE) ?
		((COORD_BITS+1)'(req.left_width_edge_x) + (COORD_BITS+1)'(req.right_width_edge_x)) :
		'0;

	assign req.ready = !vld_q || wr.ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= 1'b1;
		end else if (wr.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= {req.opcode, req.center_dx, req.center_dy,
				req.left_width_edge_x, req.left_width_edge_y,
				req.left_height_edge_x, req.left_height_edge_y,
				req.right_width_edge_x, req.right_width_edge_y,
				req.right_height_edge_x, req.right_height_edge_y,
				dsum};
		end
	end

	assign wr.valid = vld_q;
	assign wr.data  = data_q;

endmodule

FILE: rtl/core/obot_fifo.sv
// short queue between front and back end
`timescale 1ns / 1ps

module obot_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = obot_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	obot_stream_if.sink    wr,
	obot_stream_if.source  rd
);

	`include "oriented_box_overlap_test_top_macros.svh"

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             push;
	logic             pop;

	assign wr.ready = (count_q != CNTW'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	`OBOT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNTW'(DEPTH))
	`OBOT_ASSERT_NXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`OBOT_ASSERT_NXT(a_pop_shrinks, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

FILE: rtl/core/obot_back.sv
// back end: projection products, dot sums, magnitudes, axis sums and the final compare
`timescale 1ns / 1ps

module obot_back #(
	parameter int COORD_BITS = obot_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	obot_stream_if.sink   rd,
	obot_rsp_if.source    rsp
);

	`include "oriented_box_overlap_test_top_macros.svh"

	localparam int W  = COORD_BITS;
	localparam int PW = 2 * W;
	localparam int DW = PW + 1;
	localparam int AW = PW + 3;
	localparam int NE = obot_pkg::NUM_EDGES;
	localparam int NP = obot_pkg::NUM_PAIRS;
	localparam int NS = obot_pkg::BACK_STAGES;

	logic                kind;
	logic signed [W-1:0] cx;
	logic signed [W-1:0] cy;
	logic signed [W-1:0] ex [NE];
	logic signed [W-1:0] ey [NE];
	logic signed [W:0]   dsum;

	assign {kind, cx, cy, ex[0], ey[0], ex[1], ey[1], ex[2], ey[2], ex[3], ey[3], dsum} = rd.data;

	logic          adv;
	logic [NS-1:0] vld_q;

	// whole back end moves together, held only while the result beat waits
	assign adv      = !vld_q[NS-1] || rsp.ready;
	assign rd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], rd.valid};
		end
	end

	// stage 1: products
	logic                 kind_s1;
	logic signed [PW-1:0] px_s1 [NP];
	logic signed [PW-1:0] py_s1 [NP];
	logic signed [PW-1:0] cpx_s1 [NE];
	logic signed [PW-1:0] cpy_s1 [NE];
	logic signed [PW-1:0] dx2_s1;
	logic signed [PW-1:0] dy2_s1;
	logic signed [PW+1:0] rsq_s1;

	// stage 2: dot products
	logic                 kind_s2;
	logic signed [DW-1:0] dot_s2 [NP];
	logic signed [DW-1:0] cdot_s2 [NE];
	logic signed [DW-1:0] dsq_s2;
	logic signed [PW+1:0] rsq_s2;

	// stage 3: magnitudes
	logic          kind_s3;
	logic [DW-1:0] abs_s3 [NP];
	logic [DW:0]   cen_s3 [NE];
	logic          chit_s3;

	// stage 4: partial axis sums
	logic          kind_s4;
	logic [DW:0]   half_s4 [NE][2];
	logic [DW:0]   cen_s4 [NE];
	logic          chit_s4;

	// stage 5: axis sums
	logic          kind_s5;
	logic [AW-1:0] proj_s5 [NE];
	logic [DW:0]   cen_s5 [NE];
	logic          chit_s5;

	// stage 6: result register
	logic          overlap_q;

	logic [DW-1:0] abs_c [NP];
	logic [DW-1:0] cabs_c [NE];
	logic [NE-1:0] sep_c;

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			abs_c[k] = dot_s2[k][DW-1] ? DW'(-dot_s2[k]) : DW'(dot_s2[k]);
		end
		for (int i = 0; i < NE; i++) begin
			cabs_c[i] = cdot_s2[i][DW-1] ? DW'(-cdot_s2[i]) : DW'(cdot_s2[i]);
		end
		for (int i = 0; i < NE; i++) begin
			sep_c[i] = proj_s5[i] < AW'(cen_s5[i]);
		end
	end

	genvar k, i;

	generate
		for (k = 0; k < NP; k++) begin : g_pair
			always_ff @(posedge clk) begin
				if (adv) begin
					px_s1[k]  <= PW'(ex[obot_pkg::PAIR_A[k]]) * PW'(ex[obot_pkg::PAIR_B[k]]);
					py_s1[k]  <= PW'(ey[obot_pkg::PAIR_A[k]]) * PW'(ey[obot_pkg::PAIR_B[k]]);
					dot_s2[k] <= DW'(px_s1[k]) + DW'(py_s1[k]);
					abs_s3[k] <= abs_c[k];
				end
			end
		end

		for (i = 0; i < NE; i++) begin : g_axis
			always_ff @(posedge clk) begin
				if (adv) begin
					cpx_s1[i]     <= PW'(cx) * PW'(ex[i]);
					cpy_s1[i]     <= PW'(cy) * PW'(ey[i]);
					cdot_s2[i]    <= DW'(cpx_s1[i]) + DW'(cpy_s1[i]);
					cen_s3[i]     <= {cabs_c[i], 1'b0};
					half_s4[i][0] <= (DW+1)'(abs_s3[obot_pkg::PAIR_IDX[i][0]]) +
						(DW+1)'(abs_s3[obot_pkg::PAIR_IDX[i][1]]);
					half_s4[i][1] <= (DW+1)'(abs_s3[obot_pkg::PAIR_IDX[i][2]]) +
						(DW+1)'(abs_s3[obot_pkg::PAIR_IDX[i][3]]);
					cen_s4[i]     <= cen_s3[i];
					proj_s5[i]    <= AW'(half_s4[i][0]) + AW'(half_s4[i][1]);
					cen_s5[i]     <= cen_s4[i];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= kind;
			dx2_s1    <= PW'(cx) * PW'(cx);
			dy2_s1    <= PW'(cy) * PW'(cy);
			rsq_s1    <= (PW+2)'(dsum) * (PW+2)'(dsum);
			kind_s2   <= kind_s1;
			dsq_s2    <= DW'(dx2_s1) + DW'(dy2_s1);
			rsq_s2    <= rsq_s1;
			kind_s3   <= kind_s2;
			chit_s3   <= {dsq_s2, 2'b00} <= AW'($unsigned(rsq_s2));
			kind_s4   <= kind_s3;
			chit_s4   <= chit_s3;
			kind_s5   <= kind_s4;
			chit_s5   <= chit_s4;
			overlap_q <= (kind_s5 == obot_pkg::OP_CIRCLE) ? chit_s5 : ~|sep_c;
		end
	end

	assign rsp.valid   = vld_q[NS-1];
	assign rsp.overlap = overlap_q;

	`OBOT_ASSERT_NXT(a_stall_holds, clk, arst_n, !adv, vld_q == $past(vld_q))
	`OBOT_ASSERT_NXT(a_last_stage_fills, clk, arst_n, adv && vld_q[NS-2], rsp.valid)
	`OBOT_ASSERT_NXT(a_resp_held, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && (rsp.overlap == $past(rsp.overlap)))

endmodule

FILE: rtl/core/oriented_box_overlap_test_top.sv
// top level of the oriented box overlap test
// an accepted request beat passes the front end register, the queue and the six back end stages to its response beat
// throughput: one collider pair per cycle while no response beat waits, set by the six-stage back end pipeline
// a four-beat queue lets the front end keep taking beats while the back end is held
// the back end holds as a whole only while a response beat waits to be taken
// reset: arst_n clears all valid flags and queue pointers at once, no clearing pass
`timescale 1ns / 1ps

module oriented_box_overlap_test_top #(
	parameter int COORD_BITS  = obot_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = obot_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	obot_req_if.sink     req,
	obot_rsp_if.source   rsp
);

	localparam int EW = obot_pkg::entry_bits(COORD_BITS);

	obot_stream_if #(.WIDTH(EW)) front_q ();
	obot_stream_if #(.WIDTH(EW)) queue_q ();

	obot_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wr     (front_q)
	);

	obot_fifo #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_q),
		.rd     (queue_q)
	);

	obot_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (queue_q),
		.rsp    (rsp)
	);

endmodule

FILE: verif/oriented_box_overlap_test_top_tb.sv
// testbench for the oriented box overlap test: directed and random collider pairs
`timescale 1ns / 1ps

module oriented_box_overlap_test_top_tb;

	localparam logic OP_RECT   = obot_pkg::OP_RECT;
	localparam logic OP_CIRCLE = obot_pkg::OP_CIRCLE;

	localparam int CB          = obot_pkg::COORD_BITS_DEF;
	localparam int MAX_C       = 8388607;
	localparam int MIN_C       = -8388608;
	localparam int ONE         = 256;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_TAIL  = 16;
	localparam int RANDOM_PAIRS = 1500;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		logic   opcode;
		coord_t center_dx;
		coord_t center_dy;
		coord_t left_width_edge_x;
		coord_t left_width_edge_y;
		coord_t left_height_edge_x;
		coord_t left_height_edge_y;
		coord_t right_width_edge_x;
		coord_t right_width_edge_y;
		coord_t right_height_edge_x;
		coord_t right_height_edge_y;
	} pair_t;

	logic clk;
	logic arst_n;

	logic overlap_expected [$];
	int   mismatches;
	int   idle_cycles;
	bit   sender_bursts;
	bit   receiver_bursts;

	obot_req_if #(.COORD_BITS(CB)) req_bus ();
	obot_rsp_if                    rsp_bus ();

	oriented_box_overlap_test_top #(
		.COORD_BITS(CB)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint dot_magnitude(input longint ux, input longint uy,
			input longint vx, input longint vy);
		longint d;
		d = ux * vx + uy * vy;
		return (d < 0) ? -d : d;
	endfunction

	// separating-axis test for rects, squared distance test for circles
	function automatic logic pair_overlaps(input pair_t p);
		longint ex [4];
		longint ey [4];
		longint cx;
		longint cy;
		longint proj;
		longint cen;
		longint dsum;
		logic   hit;
		cx    = p.center_dx;
		cy    = p.center_dy;
		ex[0] = p.left_width_edge_x;
		ey[0] = p.left_width_edge_y;
		ex[1] = p.left_height_edge_x;
		ey[1] = p.left_height_edge_y;
		ex[2] = p.right_width_edge_x;
		ey[2] = p.right_width_edge_y;
		ex[3] = p.right_height_edge_x;
		ey[3] = p.right_height_edge_y;
		hit   = 1'b1;
		if (p.opcode == OP_CIRCLE) begin
			dsum = longint'(p.left_width_edge_x) + longint'(p.right_width_edge_x);
			hit  = (4 * (cx * cx + cy * cy)) <= (dsum * dsum);
		end else begin
			for (int i = 0; i < 4; i++) begin
				proj = 0;
				for (int j = 0; j < 4; j++)
					proj += dot_magnitude(ex[j], ey[j], ex[i], ey[i]);
				cen = 2 * dot_magnitude(cx, cy, ex[i], ey[i]);
				if (proj < cen)
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

	function automatic pair_t build_pair(input logic op, input int dx, input int dy,
			input int lwx, input int lwy, input int lhx, input int lhy,
			input int rwx, input int rwy, input int rhx, input int rhy);
		pair_t p;
		p.opcode              = op;
		p.center_dx           = coord_t'(dx);
		p.center_dy           = coord_t'(dy);
		p.left_width_edge_x   = coord_t'(lwx);
		p.left_width_edge_y   = coord_t'(lwy);
		p.left_height_edge_x  = coord_t'(lhx);
		p.left_height_edge_y  = coord_t'(lhy);
		p.right_width_edge_x  = coord_t'(rwx);
		p.right_width_edge_y  = coord_t'(rwy);
		p.right_height_edge_x = coord_t'(rhx);
		p.right_height_edge_y = coord_t'(rhy);
		return p;
	endfunction

	function automatic int rand_within(input int mag);
		return int'($urandom_range(2 * mag)) - mag;
	endfunction

	function automatic int random_coord();
		bit [31:0] r;
		r = $urandom();
		return int'(coord_t'(r[CB-1:0]));
	endfunction

	// drives one pair from a falling edge and returns at the edge that takes it
	task automatic send_pair(input pair_t p);
		int gap;
		gap = sender_bursts ? 0 : $urandom_range(17);
		@(negedge clk);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.opcode              <= p.opcode;
		req_bus.center_dx           <= p.center_dx;
		req_bus.center_dy           <= p.center_dy;
		req_bus.left_width_edge_x   <= p.left_width_edge_x;
		req_bus.left_width_edge_y   <= p.left_width_edge_y;
		req_bus.left_height_edge_x  <= p.left_height_edge_x;
		req_bus.left_height_edge_y  <= p.left_height_edge_y;
		req_bus.right_width_edge_x  <= p.right_width_edge_x;
		req_bus.right_width_edge_y  <= p.right_width_edge_y;
		req_bus.right_height_edge_x <= p.right_height_edge_x;
		req_bus.right_height_edge_y <= p.right_height_edge_y;
		req_bus.valid               <= 1'b1;
		do @(posedge clk); while (!req_bus.ready);
		overlap_expected.push_back(pair_overlaps(p));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (overlap_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_rect_directed();
		// same centre, axis-aligned unit squares
		send_pair(build_pair(OP_RECT, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		// apart along x, touching, just apart along x and along y
		send_pair(build_pair(OP_RECT, 2 * ONE, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		send_pair(build_pair(OP_RECT, ONE, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		send_pair(build_pair(OP_RECT, ONE + 1, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		send_pair(build_pair(OP_RECT, 0, -ONE - 1, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		// rotated left box against an axis-aligned one
		send_pair(build_pair(OP_RECT, 300, 300, 181, 181, -181, 181, ONE, 0, 0, ONE));
		send_pair(build_pair(OP_RECT, 200, 0, 181, 181, -181, 181, ONE, 0, 0, ONE));
		// zero-length edges cannot separate
		send_pair(build_pair(OP_RECT, 1000, -1000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(build_pair(OP_RECT, 4 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, ONE));
		// negative edge vectors
		send_pair(build_pair(OP_RECT, -600, 0, -ONE, 0, 0, -ONE, -ONE, 0, 0, ONE));
		// extremes
		send_pair(build_pair(OP_RECT, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
			MAX_C, MAX_C, MAX_C, MAX_C));
		send_pair(build_pair(OP_RECT, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
			MIN_C, MIN_C, MIN_C, MIN_C));
		send_pair(build_pair(OP_RECT, MIN_C, MAX_C, 1, 0, 0, 1, 1, 0, 0, 1));
		send_pair(build_pair(OP_RECT, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
			MAX_C, MAX_C, MIN_C, MIN_C));
	endtask

	task automatic test_circle_directed();
		// touching, just apart, negative diameters
		send_pair(build_pair(OP_CIRCLE, 2 * ONE, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, 2 * ONE + 1, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, 2 * ONE, 0, -2 * ONE, 0, 0, 0, -2 * ONE, 0, 0, 0));
		// diameters cancel, then a pair just apart along y
		send_pair(build_pair(OP_CIRCLE, 0, 0, 2 * ONE, 0, 0, 0, -2 * ONE, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, 0, 1, 2 * ONE, 0, 0, 0, -2 * ONE, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, 0, 1025, 1024, 0, 0, 0, 1024, 0, 0, 0));
		// ignored fields full of junk
		send_pair(build_pair(OP_CIRCLE, 300, -400, ONE * 4, MIN_C, MAX_C, MIN_C,
			ONE * 6, MAX_C, MIN_C, MAX_C));
		// extremes
		send_pair(build_pair(OP_CIRCLE, MIN_C, MIN_C, MAX_C, 0, 0, 0, MAX_C, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, 0, 0, MIN_C, MAX_C, MAX_C, MAX_C, MIN_C, 0, 0, 0));
		send_pair(build_pair(OP_CIRCLE, MAX_C, MAX_C, MIN_C, 0, 0, 0, MIN_C, 0, 0, 0));
	endtask

	task automatic send_random_pair();
		int    kind;
		int    mag;
		int    ax;
		int    ay;
		int    bx;
		int    by;
		int    m;
		int    n;
		pair_t p;
		kind = $urandom_range(99);
		mag  = 1 << $urandom_range(4, 19);
		if (kind < 45) begin
			ax = rand_within(mag);
			ay = rand_within(mag);
			bx = rand_within(mag);
			by = rand_within(mag);
			m  = $urandom_range(1, 8);
			n  = $urandom_range(1, 8);
			p  = build_pair(OP_RECT, rand_within(2 * mag), rand_within(2 * mag),
				ax, ay, (-ay * m) >>> 2, (ax * m) >>> 2,
				bx, by, (-by * n) >>> 2, (bx * n) >>> 2);
		end else if (kind < 75) begin
			p = build_pair(OP_CIRCLE, rand_within(mag), rand_within(mag),
				rand_within(2 * mag), random_coord(), random_coord(), random_coord(),
				rand_within(2 * mag), random_coord(), random_coord(), random_coord());
		end else begin
			p = build_pair(logic'($urandom_range(1)), random_coord(), random_coord(),
				random_coord(), random_coord(), random_coord(), random_coord(),
				random_coord(), random_coord(), random_coord(), random_coord());
		end
		send_pair(p);
	endtask

	task automatic test_drain_pause();
		repeat (30) send_random_pair();
		wait_drained();
		repeat (30) send_random_pair();
	endtask

	task automatic test_random_pairs();
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n % 100 == 0) begin
				sender_bursts   = ($urandom_range(3) == 0);
				receiver_bursts = ($urandom_range(3) == 0);
			end
			send_random_pair();
		end
		sender_bursts   = 1'b0;
		receiver_bursts = 1'b0;
	endtask

	// response side: random stall before each beat, none while receiver_bursts is set
	initial begin
		int stall;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = receiver_bursts ? 0 : $urandom_range(17);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (overlap_expected.size() == 0) begin
				$error("overlap: unexpected beat, actual %0b", rsp_bus.overlap);
				mismatches++;
			end else if (overlap_expected[0] !== rsp_bus.overlap) begin
				$error("overlap: expected %0b, actual %0b", overlap_expected[0],
					rsp_bus.overlap);
				mismatches++;
				void'(overlap_expected.pop_front());
			end else begin
				void'(overlap_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** oriented_box_overlap_test_top: FAILED **");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sender_bursts               = 1'b0;
		receiver_bursts             = 1'b0;
		arst_n                      = 1'b0;
		req_bus.valid               = 1'b0;
		req_bus.opcode              = OP_RECT;
		req_bus.center_dx           = '0;
		req_bus.center_dy           = '0;
		req_bus.left_width_edge_x   = '0;
		req_bus.left_width_edge_y   = '0;
		req_bus.left_height_edge_x  = '0;
		req_bus.left_height_edge_y  = '0;
		req_bus.right_width_edge_x  = '0;
		req_bus.right_width_edge_y  = '0;
		req_bus.right_height_edge_x = '0;
		req_bus.right_height_edge_y = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_rect_directed();
		test_circle_directed();
		test_drain_pause();
		test_random_pairs();

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("** oriented_box_overlap_test_top: PASSED **");
		else
			$display("** oriented_box_overlap_test_top: FAILED **");
		$finish;
	end

endmodule
